FILE: design/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared constants, command codes and the request type for the modular unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int WORD_BITS = 31;
    localparam int OPER_BITS = 32;
    localparam int CNT_BITS  = $clog2(OPER_BITS);

    localparam logic [WORD_BITS-1:0] MOD_RESET = WORD_BITS'(998244353);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_POW = 3'd3;
    localparam logic [2:0] CMD_INV = 3'd4;

    // x * y mod m, bit-serial; with y = 1 it is x / m with remainder
    typedef struct packed {
        logic [OPER_BITS-1:0] x;
        logic [WORD_BITS-1:0] y;
        logic [WORD_BITS-1:0] m;
    } mau_req_t;

endpackage

FILE: design/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply, power and inverse modulo a configured modulus.
// ----------------------------------------------------------------------------
// One request at a time; busy stays high until the cycle after its result is
// shown on result with done high for one cycle, and the receiver cannot stall
// it. Reductions and products all run through one bit-serial multiplier.
// Add and subtract reduce both operands and combine them; multiply reduces
// operand_a and multiplies it by operand_b. Power squares once per exponent
// bit up to the top set bit and multiplies once more per set bit; inverse
// runs a division and a multiply pass per Euclid step (at most about 45
// steps). A modulus below 2 or an unused command gives 0 with no pass.
module modular_arithmetic_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    cmd,
    input  logic [mau_pkg::WORD_BITS-1:0] operand_a,
    input  logic [mau_pkg::OPER_BITS-1:0] operand_b,
    output logic                          done,
    output logic [mau_pkg::WORD_BITS-1:0] result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mau_pkg::WORD_BITS-1:0] cfg_data
);
    import mau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_PCHK = 4'd4;
    localparam logic [3:0] S_PM   = 4'd5;
    localparam logic [3:0] S_PS   = 4'd6;
    localparam logic [3:0] S_ICHK = 4'd7;
    localparam logic [3:0] S_IDIV = 4'd8;
    localparam logic [3:0] S_IMUL = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [WORD_BITS-1:0] mod_reg, mod_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [WORD_BITS-1:0] p_reg, p_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [OPER_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] rn_reg, rn_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic                 done_reg, done_next;
    logic                 ustart_reg, ustart_next;
    mau_req_t             ureq_reg, ureq_next;

    logic                 u_done;
    logic [WORD_BITS-1:0] u_acc;
    logic [OPER_BITS-1:0] u_quo;
    logic [WORD_BITS:0]   sum, diff;
    logic [WORD_BITS-1:0] one;

    mau_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ustart_reg),
        .req   (ureq_reg),
        .done  (u_done),
        .acc   (u_acc),
        .quo   (u_quo)
    );

    assign one = WORD_BITS'(1);

    always_comb
    begin
        state_next  = state_reg;
        mod_next    = mod_reg;
        cmd_next    = cmd_reg;
        p_next      = p_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        r_next      = r_reg;
        rn_next     = rn_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        ustart_next = 1'b0;
        ureq_next   = ureq_reg;
        sum         = '0;
        diff        = '0;

        if (cfg_valid)
            mod_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    p_next   = mod_reg;
                    a_next   = operand_a;
                    b_next   = operand_b;
                    if (mod_reg < WORD_BITS'(2) || cmd > CMD_INV)
                    begin
                        res_next   = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ureq_next   = '{x: {1'b0, operand_a}, y: one, m: mod_reg};
                        ustart_next = 1'b1;
                        state_next  = S_RA;
                    end
                end
            end
            S_RA:
            begin
                if (u_done)
                begin
                    a_next = u_acc;
                    unique case (cmd_reg)
                        CMD_ADD, CMD_SUB:
                        begin
                            ureq_next   = '{x: b_reg, y: one, m: p_reg};
                            ustart_next = 1'b1;
                            state_next  = S_RB;
                        end
                        CMD_MUL:
                        begin
                            ureq_next   = '{x: b_reg, y: u_acc, m: p_reg};
                            ustart_next = 1'b1;
                            state_next  = S_MUL;
                        end
                        CMD_POW:
                        begin
                            acc_next   = one;
                            base_next  = u_acc;
                            state_next = S_PCHK;
                        end
                        default:
                        begin
                            r_next     = u_acc;
                            rn_next    = p_reg;
                            acc_next   = one;
                            base_next  = '0;
                            state_next = S_ICHK;
                        end
                    endcase
                end
            end
            S_RB:
            begin
                if (u_done)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        sum      = {1'b0, a_reg} + {1'b0, u_acc};
                        res_next = (sum >= {1'b0, p_reg}) ? WORD_BITS'(sum - {1'b0, p_reg})
                                                          : sum[WORD_BITS-1:0];
                    end
                    else if (a_reg < u_acc)
                        res_next = p_reg - (u_acc - a_reg);
                    else
                        res_next = a_reg - u_acc;
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                if (u_done)
                begin
                    res_next   = u_acc;
                    state_next = S_FIN;
                end
            end
            S_PCHK:
            begin
                if (b_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = S_FIN;
                end
                else if (b_reg[0])
                begin
                    ureq_next   = '{x: {1'b0, acc_reg}, y: base_reg, m: p_reg};
                    ustart_next = 1'b1;
                    state_next  = S_PM;
                end
                else
                begin
                    ureq_next   = '{x: {1'b0, base_reg}, y: base_reg, m: p_reg};
                    ustart_next = 1'b1;
                    state_next  = S_PS;
                end
            end
            S_PM:
            begin
                if (u_done)
                begin
                    acc_next    = u_acc;
                    ureq_next   = '{x: {1'b0, base_reg}, y: base_reg, m: p_reg};
                    ustart_next = 1'b1;
                    state_next  = S_PS;
                end
            end
            S_PS:
            begin
                if (u_done)
                begin
                    base_next  = u_acc;
                    b_next     = {1'b0, b_reg[OPER_BITS-1:1]};
                    state_next = S_PCHK;
                end
            end
            S_ICHK:
            begin
                if (rn_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    // quotient and remainder of r / rn
                    ureq_next   = '{x: {1'b0, r_reg}, y: one, m: rn_reg};
                    ustart_next = 1'b1;
                    state_next  = S_IDIV;
                end
            end
            S_IDIV:
            begin
                if (u_done)
                begin
                    b_next      = {1'b0, u_acc};
                    ureq_next   = '{x: u_quo, y: base_reg, m: p_reg};
                    ustart_next = 1'b1;
                    state_next  = S_IMUL;
                end
            end
            S_IMUL:
            begin
                if (u_done)
                begin
                    // coefficients kept reduced mod p
                    diff      = {1'b0, acc_reg} + {1'b0, p_reg} - {1'b0, u_acc};
                    base_next = (acc_reg >= u_acc) ? acc_reg - u_acc : diff[WORD_BITS-1:0];
                    acc_next  = base_reg;
                    r_next    = rn_reg;
                    rn_next   = b_reg[WORD_BITS-1:0];
                    state_next = S_ICHK;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mod_reg    <= MOD_RESET;
            done_reg   <= 1'b0;
            ustart_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mod_reg    <= mod_next;
            done_reg   <= done_next;
            ustart_reg <= ustart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        r_reg    <= r_next;
        rn_reg   <= rn_next;
        res_reg  <= res_next;
        ureq_reg <= ureq_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: design/mau_mulmod.sv
// ----------------------------------------------------------------------------
// mau_mulmod
// Shared double-and-add modular multiplier, one operand bit per cycle.
// ----------------------------------------------------------------------------
module mau_mulmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mau_pkg::mau_req_t             req,
    output logic                          done,
    output logic [mau_pkg::WORD_BITS-1:0] acc,
    output logic [mau_pkg::OPER_BITS-1:0] quo
);
    import mau_pkg::*;

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [OPER_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [OPER_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS+1:0] t0, t1, t2, mw;
    logic                 qbit;

    always_comb
    begin
        mw   = {2'b00, m_reg};
        t0   = {1'b0, acc_reg, 1'b0} + (x_reg[OPER_BITS-1] ? {2'b00, y_reg} : '0);
        qbit = (t0 >= mw);
        t1   = qbit ? t0 - mw : t0;
        t2   = (t1 >= mw) ? t1 - mw : t1;
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        m_next      = m_reg;
        acc_next    = acc_reg;
        quo_next    = quo_reg;
        if (active_reg)
        begin
            acc_next = t2[WORD_BITS-1:0];
            quo_next = {quo_reg[OPER_BITS-2:0], qbit};
            x_next   = {x_reg[OPER_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(OPER_BITS-1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
        else if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            x_next      = req.x;
            y_next      = req.y;
            m_next      = req.m;
            acc_next    = '0;
            quo_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = quo_reg;

endmodule
